// ----- src/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, codes and the turn dictionary of the path smoother.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Raw path symbols
  localparam logic [2:0] SYM_B = 3'd0;
  localparam logic [2:0] SYM_S = 3'd1;
  localparam logic [2:0] SYM_F = 3'd2;
  localparam logic [2:0] SYM_L = 3'd3;
  localparam logic [2:0] SYM_R = 3'd4;

  // Smooth movement codes
  localparam logic [4:0] MV_START      = 5'd0;
  localparam logic [4:0] MV_STOP       = 5'd1;
  localparam logic [4:0] MV_FRONT      = 5'd2;
  localparam logic [4:0] MV_LEFT       = 5'd3;
  localparam logic [4:0] MV_RIGHT      = 5'd4;
  localparam logic [4:0] MV_LEFT_90    = 5'd5;
  localparam logic [4:0] MV_RIGHT_90   = 5'd6;
  localparam logic [4:0] MV_LEFT_180   = 5'd7;
  localparam logic [4:0] MV_RIGHT_180  = 5'd8;
  localparam logic [4:0] MV_LEFT_TO45  = 5'd9;
  localparam logic [4:0] MV_RIGHT_TO45 = 5'd10;
  localparam logic [4:0] MV_LEFT_TO135 = 5'd11;
  localparam logic [4:0] MV_RIGHT_TO135 = 5'd12;
  localparam logic [4:0] MV_LEFT_FR45  = 5'd13;
  localparam logic [4:0] MV_RIGHT_FR45 = 5'd14;
  localparam logic [4:0] MV_LEFT_FR135 = 5'd15;
  localparam logic [4:0] MV_RIGHT_FR135 = 5'd16;
  localparam logic [4:0] MV_DIAG       = 5'd17;
  localparam logic [4:0] MV_LEFT_DIAG  = 5'd18;
  localparam logic [4:0] MV_RIGHT_DIAG = 5'd19;
  localparam logic [4:0] MV_END        = 5'd20;

  // Heading modes
  localparam logic MODE_ORTHO = 1'b0;
  localparam logic MODE_DIAG  = 1'b1;

  localparam int         WIN_DEPTH   = 3;
  localparam logic [2:0] MAX_RESULTS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_TAIL,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_PARTIAL,
    RES_MATCH,
    RES_END
  } scan_res_t;

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][2:0] sym;
    logic [4:0]      code;
  } pattern_t;

  function automatic pattern_t mk_pat(logic [1:0] len, logic [2:0] s0, logic [2:0] s1,
                                      logic [2:0] s2, logic [4:0] code);
    pattern_t p;
    p.len    = len;
    p.sym[0] = s0;
    p.sym[1] = s1;
    p.sym[2] = s2;
    p.code   = code;
    return p;
  endfunction

  // Number of entries for a dictionary and mode
  function automatic logic [3:0] pattern_count(logic dict, logic mode);
    logic [3:0] n;
    case ({dict, mode})
      2'b00:   n = 4'd4;
      2'b01:   n = 4'd6;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // Dictionary entry, in first-match order
  function automatic pattern_t dict_entry(logic dict, logic mode, logic [2:0] idx);
    pattern_t p;
    case ({dict, mode, idx})
      // safe dictionary, orthogonal mode
      5'b00_000: p = mk_pat(2'd2, SYM_L, SYM_F, SYM_B, MV_LEFT_90);
      5'b00_001: p = mk_pat(2'd2, SYM_R, SYM_F, SYM_B, MV_RIGHT_90);
      5'b00_010: p = mk_pat(2'd3, SYM_L, SYM_L, SYM_F, MV_LEFT_180);
      5'b00_011: p = mk_pat(2'd3, SYM_R, SYM_R, SYM_F, MV_RIGHT_180);
      // safe dictionary, diagonal mode
      5'b01_000: p = mk_pat(2'd2, SYM_L, SYM_L, SYM_B, MV_LEFT);
      5'b01_001: p = mk_pat(2'd2, SYM_R, SYM_R, SYM_B, MV_RIGHT);
      5'b01_010: p = mk_pat(2'd2, SYM_L, SYM_R, SYM_B, MV_LEFT);
      5'b01_011: p = mk_pat(2'd2, SYM_R, SYM_L, SYM_B, MV_RIGHT);
      5'b01_100: p = mk_pat(2'd2, SYM_L, SYM_F, SYM_B, MV_LEFT);
      5'b01_101: p = mk_pat(2'd2, SYM_R, SYM_F, SYM_B, MV_RIGHT);
      // diagonal dictionary, orthogonal mode
      5'b10_000: p = mk_pat(2'd2, SYM_L, SYM_F, SYM_B, MV_LEFT_90);
      5'b10_001: p = mk_pat(2'd2, SYM_R, SYM_F, SYM_B, MV_RIGHT_90);
      5'b10_010: p = mk_pat(2'd2, SYM_L, SYM_R, SYM_B, MV_LEFT_TO45);
      5'b10_011: p = mk_pat(2'd2, SYM_R, SYM_L, SYM_B, MV_RIGHT_TO45);
      5'b10_100: p = mk_pat(2'd3, SYM_L, SYM_L, SYM_F, MV_LEFT_180);
      5'b10_101: p = mk_pat(2'd3, SYM_R, SYM_R, SYM_F, MV_RIGHT_180);
      5'b10_110: p = mk_pat(2'd3, SYM_L, SYM_L, SYM_R, MV_LEFT_TO135);
      5'b10_111: p = mk_pat(2'd3, SYM_R, SYM_R, SYM_L, MV_RIGHT_TO135);
      // diagonal dictionary, diagonal mode
      5'b11_000: p = mk_pat(2'd2, SYM_L, SYM_R, SYM_B, MV_DIAG);
      5'b11_001: p = mk_pat(2'd2, SYM_R, SYM_L, SYM_B, MV_DIAG);
      5'b11_010: p = mk_pat(2'd2, SYM_L, SYM_F, SYM_B, MV_LEFT_FR45);
      5'b11_011: p = mk_pat(2'd2, SYM_R, SYM_F, SYM_B, MV_RIGHT_FR45);
      5'b11_100: p = mk_pat(2'd3, SYM_L, SYM_L, SYM_R, MV_LEFT_DIAG);
      5'b11_101: p = mk_pat(2'd3, SYM_R, SYM_R, SYM_L, MV_RIGHT_DIAG);
      5'b11_110: p = mk_pat(2'd3, SYM_L, SYM_L, SYM_F, MV_LEFT_FR135);
      5'b11_111: p = mk_pat(2'd3, SYM_R, SYM_R, SYM_F, MV_RIGHT_FR135);
      default:   p = mk_pat(2'd0, SYM_B, SYM_B, SYM_B, MV_START);
    endcase
    return p;
  endfunction

endpackage

// ----- src/turn_path_smoother.sv -----
// ----------------------------------------------------------------------------
// turn_path_smoother
// Turns a raw path of begin/stop/front/left/right symbols into smooth moves
// through a three-entry lookahead window and a first-match turn dictionary.
// ----------------------------------------------------------------------------
// Each accepted symbol passes a head step per window step, then the entry-serial
//   compare unit scans one entry per step, with a miss step (twice after an
//   orthogonal miss), then tail and flush; a result may wait on move_ready.
//   A new symbol is taken only once the last one is through, back in idle.
// Reset: synchronous; empties the window, selects diagonal mode and the safe
//   dictionary, and drops any result in flight.
module turn_path_smoother (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       path_valid,
  output logic       path_ready,
  input  logic [2:0] path_symbol,
  input  logic       path_done,
  output logic       move_valid,
  input  logic       move_ready,
  output logic [4:0] move_code,
  output logic       bad_path,
  output logic       run_last
);

  tps_pkg::state_t    state, state_next;
  tps_pkg::scan_res_t scan_res;
  tps_pkg::pattern_t  pat;

  logic       dict_sel;
  logic       mode, mode_next;
  logic [2:0] win [tps_pkg::WIN_DEPTH];
  logic [2:0] win_next [tps_pkg::WIN_DEPTH];
  logic [1:0] fill, fill_next;
  logic       done_r, done_r_next;
  logic [3:0] scan_idx, scan_idx_next;
  logic [2:0] emit_cnt, emit_cnt_next;
  logic       held_v, held_v_next;
  logic [4:0] held_code, held_code_next;
  logic       held_bad, held_bad_next;
  logic       move_valid_next;
  logic [4:0] move_code_next;
  logic       bad_path_next;
  logic       run_last_next;

  logic       slot_free;
  logic       emit_want, emit_go, stall;
  logic [4:0] emit_code;
  logic       emit_bad;
  logic       head_simple;
  logic       pop_en;
  logic [1:0] pop_n;
  logic       clear_win;
  logic       accept;

  assign path_ready  = (state == tps_pkg::ST_IDLE);
  assign accept      = path_valid && path_ready;
  assign slot_free   = !move_valid || move_ready;
  assign head_simple = (win[0] == tps_pkg::SYM_B) || (win[0] == tps_pkg::SYM_S) ||
                       (win[0] == tps_pkg::SYM_F);

  // Compare unit: test the window against one dictionary entry per cycle unless the step is stalled
  always_comb begin
    logic stop;
    pat      = tps_pkg::dict_entry(dict_sel, mode, scan_idx[2:0]);
    scan_res = tps_pkg::RES_MATCH;
    stop     = 1'b0;
    if (scan_idx >= tps_pkg::pattern_count(dict_sel, mode)) begin
      scan_res = tps_pkg::RES_END;
    end else begin
      for (int i = 0; i < tps_pkg::WIN_DEPTH; i++) begin
        if (!stop && (2'(i) < pat.len)) begin
          if (2'(i) >= fill) begin
            scan_res = tps_pkg::RES_PARTIAL;
            stop     = 1'b1;
          end else if (win[i] != pat.sym[i]) begin
            scan_res = tps_pkg::RES_FAIL;
            stop     = 1'b1;
          end
        end
      end
    end
  end

  // Decide whether this step produces a result
  always_comb begin
    emit_want = 1'b0;
    emit_code = tps_pkg::MV_START;
    emit_bad  = 1'b0;
    case (state)
      tps_pkg::ST_HEAD: begin
        if (fill != 2'd0 && head_simple) begin
          emit_want = 1'b1;
          if (win[0] == tps_pkg::SYM_B) begin
            emit_code = tps_pkg::MV_START;
          end else if (win[0] == tps_pkg::SYM_S) begin
            emit_code = tps_pkg::MV_STOP;
          end else begin
            emit_code = tps_pkg::MV_FRONT;
          end
        end
      end
      tps_pkg::ST_SCAN: begin
        if (scan_res == tps_pkg::RES_MATCH) begin
          emit_want = 1'b1;
          emit_code = pat.code;
        end else if (scan_res == tps_pkg::RES_END && mode == tps_pkg::MODE_DIAG) begin
          emit_want = 1'b1;
          emit_code = tps_pkg::MV_START;
          emit_bad  = 1'b1;
        end
      end
      tps_pkg::ST_TAIL: begin
        emit_want = done_r;
        emit_code = tps_pkg::MV_END;
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  // Hold the step while the held result cannot move to the output register
  assign stall = (emit_want && (emit_cnt != tps_pkg::MAX_RESULTS) && held_v && !slot_free) ||
                 (state == tps_pkg::ST_FLUSH && held_v && !slot_free);
  assign emit_go = emit_want && (emit_cnt != tps_pkg::MAX_RESULTS) && !stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tps_pkg::ST_IDLE: begin
        if (accept) state_next = tps_pkg::ST_HEAD;
      end
      tps_pkg::ST_HEAD: begin
        if (!stall) begin
          if (fill == 2'd0) begin
            state_next = tps_pkg::ST_TAIL;
          end else if (!head_simple) begin
            state_next = tps_pkg::ST_SCAN;
          end
        end
      end
      tps_pkg::ST_SCAN: begin
        if (!stall) begin
          case (scan_res)
            tps_pkg::RES_FAIL:    state_next = tps_pkg::ST_SCAN;
            tps_pkg::RES_PARTIAL: state_next = done_r ? tps_pkg::ST_SCAN : tps_pkg::ST_TAIL;
            tps_pkg::RES_MATCH:   state_next = tps_pkg::ST_HEAD;
            default: begin
              state_next = (mode == tps_pkg::MODE_ORTHO) ? tps_pkg::ST_SCAN : tps_pkg::ST_HEAD;
            end
          endcase
        end
      end
      tps_pkg::ST_TAIL: begin
        if (!stall) state_next = tps_pkg::ST_FLUSH;
      end
      tps_pkg::ST_FLUSH: begin
        if (!stall) state_next = tps_pkg::ST_IDLE;
      end
      default: begin
        state_next = tps_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath: window, mode, held result and output register
  always_comb begin
    mode_next       = mode;
    fill_next       = fill;
    done_r_next     = done_r;
    scan_idx_next   = scan_idx;
    emit_cnt_next   = emit_cnt;
    held_v_next     = held_v;
    held_code_next  = held_code;
    held_bad_next   = held_bad;
    move_valid_next = move_valid;
    move_code_next  = move_code;
    bad_path_next   = bad_path;
    run_last_next   = run_last;
    pop_en          = 1'b0;
    pop_n           = 2'd0;
    clear_win       = 1'b0;
    for (int i = 0; i < tps_pkg::WIN_DEPTH; i++) win_next[i] = win[i];

    // Drop the output once the sink takes it
    if (move_valid && move_ready) move_valid_next = 1'b0;

    // Push the held result out and hold the new one
    if (emit_go) begin
      if (held_v) begin
        move_valid_next = 1'b1;
        move_code_next  = held_code;
        bad_path_next   = held_bad;
        run_last_next   = 1'b0;
      end
      held_v_next    = 1'b1;
      held_code_next = emit_code;
      held_bad_next  = emit_bad;
      emit_cnt_next  = emit_cnt + 3'd1;
    end

    case (state)
      tps_pkg::ST_IDLE: begin
        if (accept) begin
          done_r_next   = path_done;
          emit_cnt_next = 3'd0;
          if (path_symbol <= tps_pkg::SYM_R && fill < 2'd3) begin
            win_next[fill] = path_symbol;
            fill_next      = fill + 2'd1;
          end
        end
      end
      tps_pkg::ST_HEAD: begin
        if (!stall && fill != 2'd0) begin
          if (head_simple) begin
            pop_en = 1'b1;
            pop_n  = 2'd1;
            if (win[0] == tps_pkg::SYM_F) mode_next = tps_pkg::MODE_ORTHO;
          end else begin
            scan_idx_next = 4'd0;
          end
        end
      end
      tps_pkg::ST_SCAN: begin
        if (!stall) begin
          case (scan_res)
            tps_pkg::RES_FAIL: begin
              scan_idx_next = scan_idx + 4'd1;
            end
            tps_pkg::RES_PARTIAL: begin
              if (done_r) scan_idx_next = scan_idx + 4'd1;
            end
            tps_pkg::RES_MATCH: begin
              pop_en    = 1'b1;
              pop_n     = pat.len - 2'd1;
              mode_next = tps_pkg::MODE_DIAG;
            end
            default: begin
              // retry in diagonal mode, else drop the unmatched head
              if (mode == tps_pkg::MODE_ORTHO) begin
                mode_next     = tps_pkg::MODE_DIAG;
                scan_idx_next = 4'd0;
              end else begin
                pop_en = 1'b1;
                pop_n  = 2'd1;
              end
            end
          endcase
        end
      end
      tps_pkg::ST_TAIL: begin
        if (!stall && done_r) begin
          mode_next = tps_pkg::MODE_DIAG;
          fill_next = 2'd0;
          clear_win = 1'b1;
        end
      end
      tps_pkg::ST_FLUSH: begin
        if (held_v && slot_free) begin
          move_valid_next = 1'b1;
          move_code_next  = held_code;
          bad_path_next   = held_bad;
          run_last_next   = 1'b1;
          held_v_next     = 1'b0;
        end
      end
      default: begin
        pop_en = 1'b0;
      end
    endcase

    // Advance the window by the consumed symbols
    if (pop_en) begin
      case (pop_n)
        2'd1: begin
          win_next[0] = win[1];
          win_next[1] = win[2];
          win_next[2] = 3'd0;
        end
        2'd2: begin
          win_next[0] = win[2];
          win_next[1] = 3'd0;
          win_next[2] = 3'd0;
        end
        default: begin
          win_next = win;
        end
      endcase
      fill_next = fill - pop_n;
    end
    if (clear_win) begin
      for (int i = 0; i < tps_pkg::WIN_DEPTH; i++) win_next[i] = 3'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tps_pkg::ST_IDLE;
      dict_sel   <= 1'b0;
      mode       <= tps_pkg::MODE_DIAG;
      fill       <= 2'd0;
      done_r     <= 1'b0;
      scan_idx   <= 4'd0;
      emit_cnt   <= 3'd0;
      held_v     <= 1'b0;
      move_valid <= 1'b0;
      for (int i = 0; i < tps_pkg::WIN_DEPTH; i++) win[i] <= 3'd0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      fill       <= fill_next;
      done_r     <= done_r_next;
      scan_idx   <= scan_idx_next;
      emit_cnt   <= emit_cnt_next;
      held_v     <= held_v_next;
      move_valid <= move_valid_next;
      for (int i = 0; i < tps_pkg::WIN_DEPTH; i++) win[i] <= win_next[i];
      if (cfg_we) dict_sel <= cfg_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_code <= held_code_next;
    held_bad  <= held_bad_next;
    move_code <= move_code_next;
    bad_path  <= bad_path_next;
    run_last  <= run_last_next;
  end

endmodule

// ----- src/tps_checker.sv -----
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks on the path smoother, bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic       cfg_wdata,
  input logic       path_valid,
  input logic       path_ready,
  input logic [2:0] path_symbol,
  input logic       path_done,
  input logic       move_valid,
  input logic       move_ready,
  input logic [4:0] move_code,
  input logic       bad_path,
  input logic       run_last
);

  // A stalled output transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    move_valid && !move_ready |=> move_valid && $stable(move_code) &&
      $stable(bad_path) && $stable(run_last))
    else $error("output transaction changed while stalled");

  // An accepted symbol closes the input until its results are queued
  assert property (@(posedge clk) disable iff (rst)
    path_valid && path_ready |=> !path_ready)
    else $error("input reopened right after a transaction");

  // An unmatched window reports the start code
  assert property (@(posedge clk) disable iff (rst)
    move_valid && bad_path |-> move_code == tps_pkg::MV_START)
    else $error("bad_path with a move code other than start");

  // The end marker closes the run of results for its symbol
  assert property (@(posedge clk) disable iff (rst)
    move_valid && move_code == tps_pkg::MV_END |-> run_last && !bad_path)
    else $error("end marker not flagged as last result");

  // No code beyond the end marker
  assert property (@(posedge clk) disable iff (rst)
    move_valid |-> move_code <= tps_pkg::MV_END)
    else $error("move code out of range");

endmodule

bind turn_path_smoother tps_checker u_tps_checker (.*);
